// ----- rtl/vnorm_pkg.sv -----
// shared types, widths and step functions for the vector normaliser
package vnorm_pkg;

	localparam int CoordWidth = 16;
	localparam int UnitFrac   = 14;
	localparam int OutWidth   = 16;
	localparam int AbsWidth   = CoordWidth + 1;
	localparam int SqWidth    = 2 * CoordWidth;
	localparam int SumWidth   = SqWidth + 1;
	localparam int RemWidth   = SumWidth + 1;
	localparam int DivSteps   = 2 * UnitFrac + 1;
	localparam int RootSteps  = RemWidth / 2;

	// control that travels with each beat
	typedef struct packed {
		logic valid;
		logic zero;
		logic neg_x;
		logic neg_y;
	} ctl_t;

	// one restoring division step: compare, subtract, shift
	function automatic logic [RemWidth:0] div_step(
		input logic [RemWidth-1:0] rem,
		input logic [SumWidth-1:0] den
	);
		logic [RemWidth-1:0] ext;
		logic                ge;
		logic [RemWidth-1:0] diff;
		ext  = {1'b0, den};
		ge   = (rem >= ext);
		diff = ge ? (rem - ext) : rem;
		return {diff[RemWidth-2:0], 1'b0, ge};
	endfunction

	// one digit of the integer square root, res and rad packed as {res, rad}
	function automatic logic [2*RemWidth-1:0] root_step(
		input logic [RemWidth-1:0] rad,
		input logic [RemWidth-1:0] res,
		input logic [RemWidth-1:0] bitv
	);
		logic [RemWidth-1:0] trial;
		trial = res + bitv;
		if (rad >= trial) begin
			return {(res >> 1) + bitv, rad - trial};
		end
		return {res >> 1, rad};
	endfunction

endpackage

// ----- rtl/vector2d_normalize_core.sv -----
// top level of the 2d vector normaliser: stream ports, output register, checks
//
// Usage
//   s_* channel takes one vector per beat, m_* channel gives one result per
//   vector in the same order. Between input beat and output beat lie
//   3 front stages (abs, square, sum), 29 divider stages (one quotient
//   bit each), 17 square root stages (one digit each) and the output register.
//   Throughput is one vector per cycle unless the output stalls; every stage holds one beat.
//   Length is floor(sqrt(x*x+y*y)) in Q16.0, unit coordinates are truncated
//   Q1.14. A zero vector gives zero outputs with zero_vector set.
//   Reset clears all valid bits; nothing is in flight afterwards.
//   When the receiver holds m_tready low with a result waiting, the whole
//   pipeline freezes and s_tready drops in the same cycle; no beat is lost
//   or repeated and the waiting result holds steady.
module vector2d_normalize_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // vec_x [15:0], vec_y [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // unit_x [15:0], unit_y [31:16], vec_length [47:32]
	output logic        m_tuser   // zero_vector
);

	localparam int CW = vnorm_pkg::CoordWidth;
	localparam int OW = vnorm_pkg::OutWidth;
	localparam int RW = vnorm_pkg::RemWidth;

	logic en;
	vnorm_pkg::ctl_t ctl_f, ctl_d, ctl_r;
	logic [vnorm_pkg::SumWidth-1:0] sum_f, sum_d;
	logic [vnorm_pkg::SqWidth-1:0]  sqx_f, sqy_f;
	logic [RW-1:0] quo_x, quo_y, root_l, root_x, root_y;
	logic          out_valid_q;
	logic          out_zero_q;
	logic [OW-1:0] out_ux_q, out_uy_q, out_len_q;
	logic [OW-1:0] ux_n, uy_n, len_n;

	// pipeline advances unless a result is stuck at the output
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	vnorm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(s_tvalid),
		.vec_x   (s_tdata[CW-1:0]),
		.vec_y   (s_tdata[2*CW-1:CW]),
		.ctl_out (ctl_f),
		.sum_out (sum_f),
		.sqx_out (sqx_f),
		.sqy_out (sqy_f)
	);

	vnorm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (ctl_f),
		.sum_in (sum_f),
		.sqx_in (sqx_f),
		.sqy_in (sqy_f),
		.ctl_out(ctl_d),
		.sum_out(sum_d),
		.quo_x  (quo_x),
		.quo_y  (quo_y)
	);

	vnorm_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (ctl_d),
		.rad_l  ({1'b0, sum_d}),
		.rad_x  (quo_x),
		.rad_y  (quo_y),
		.ctl_out(ctl_r),
		.root_l (root_l),
		.root_x (root_x),
		.root_y (root_y)
	);

	// sign, saturation and zero handling
	always_comb begin
		len_n = (root_l > RW'({OW{1'b1}})) ? {OW{1'b1}} : root_l[OW-1:0];
		ux_n  = ctl_r.neg_x ? (OW'(0) - root_x[OW-1:0]) : root_x[OW-1:0];
		uy_n  = ctl_r.neg_y ? (OW'(0) - root_y[OW-1:0]) : root_y[OW-1:0];
		if (ctl_r.zero) begin
			len_n = '0;
			ux_n  = '0;
			uy_n  = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_r.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_zero_q <= ctl_r.zero;
			out_ux_q   <= ux_n;
			out_uy_q   <= uy_n;
			out_len_q  <= len_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_len_q, out_uy_q, out_ux_q};
	assign m_tuser  = out_zero_q;

	// a zero vector carries zero length and zero unit coordinates
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("zero vector with non-zero outputs");

	// a non-zero vector has a non-zero length
	a_len_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[47:32] != '0)
		else $error("non-zero vector with zero length");

	// input is refused only while a result waits at the output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

endmodule

// ----- rtl/vnorm_front.sv -----
// front end: absolute values, squares and sum of squares over three stages
module vnorm_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic signed [vnorm_pkg::CoordWidth-1:0] vec_x,
	input  logic signed [vnorm_pkg::CoordWidth-1:0] vec_y,
	output vnorm_pkg::ctl_t                       ctl_out,
	output logic [vnorm_pkg::SumWidth-1:0]        sum_out,
	output logic [vnorm_pkg::SqWidth-1:0]         sqx_out,
	output logic [vnorm_pkg::SqWidth-1:0]         sqy_out
);

	vnorm_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [vnorm_pkg::AbsWidth-1:0] ax_s1, ay_s1;
	logic [vnorm_pkg::SqWidth-1:0]  sqx_s2, sqy_s2, sqx_s3, sqy_s3;
	logic [vnorm_pkg::SumWidth-1:0] sum_s3;
	logic [2*vnorm_pkg::AbsWidth-1:0] px, py;
	logic [vnorm_pkg::SumWidth-1:0] sum_n;

	assign px    = ax_s1 * ax_s1;
	assign py    = ay_s1 * ay_s1;
	assign sum_n = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.zero  <= 1'b0;
			ctl_s1.neg_x <= vec_x[vnorm_pkg::CoordWidth-1];
			ctl_s1.neg_y <= vec_y[vnorm_pkg::CoordWidth-1];
			ctl_s2       <= ctl_s1;
			ctl_s3.valid <= ctl_s2.valid;
			ctl_s3.zero  <= (sum_n == '0);
			ctl_s3.neg_x <= ctl_s2.neg_x;
			ctl_s3.neg_y <= ctl_s2.neg_y;
		end
	end

	// datapath: abs, square, sum
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= vec_x[vnorm_pkg::CoordWidth-1]
				? ({vnorm_pkg::AbsWidth{1'b0}} - {vec_x[vnorm_pkg::CoordWidth-1], vec_x})
				: {1'b0, vec_x};
			ay_s1  <= vec_y[vnorm_pkg::CoordWidth-1]
				? ({vnorm_pkg::AbsWidth{1'b0}} - {vec_y[vnorm_pkg::CoordWidth-1], vec_y})
				: {1'b0, vec_y};
			sqx_s2 <= px[vnorm_pkg::SqWidth-1:0];
			sqy_s2 <= py[vnorm_pkg::SqWidth-1:0];
			sqx_s3 <= sqx_s2;
			sqy_s3 <= sqy_s2;
			sum_s3 <= sum_n;
		end
	end

	assign ctl_out = ctl_s3;
	assign sum_out = sum_s3;
	assign sqx_out = sqx_s3;
	assign sqy_out = sqy_s3;

endmodule

// ----- rtl/vnorm_div.sv -----
// restoring divider chain, one quotient bit per stage, x and y lanes side by side
module vnorm_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  vnorm_pkg::ctl_t                 ctl_in,
	input  logic [vnorm_pkg::SumWidth-1:0]  sum_in,
	input  logic [vnorm_pkg::SqWidth-1:0]   sqx_in,
	input  logic [vnorm_pkg::SqWidth-1:0]   sqy_in,
	output vnorm_pkg::ctl_t                 ctl_out,
	output logic [vnorm_pkg::SumWidth-1:0]  sum_out,
	output logic [vnorm_pkg::RemWidth-1:0]  quo_x,
	output logic [vnorm_pkg::RemWidth-1:0]  quo_y
);

	localparam int N = vnorm_pkg::DivSteps;
	localparam int RW = vnorm_pkg::RemWidth;

	vnorm_pkg::ctl_t                 ctl_s [N+1];
	logic [vnorm_pkg::SumWidth-1:0]  sum_s [N+1];
	logic [RW-1:0]                   rem_x_s [N+1];
	logic [RW-1:0]                   rem_y_s [N+1];
	logic [N-1:0]                    quo_x_s [N+1];
	logic [N-1:0]                    quo_y_s [N+1];

	assign ctl_s[0]   = ctl_in;
	assign sum_s[0]   = sum_in;
	assign rem_x_s[0] = {2'b00, sqx_in};
	assign rem_y_s[0] = {2'b00, sqy_in};
	assign quo_x_s[0] = '0;
	assign quo_y_s[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [RW:0] nx, ny;
		assign nx = vnorm_pkg::div_step(rem_x_s[k], sum_s[k]);
		assign ny = vnorm_pkg::div_step(rem_y_s[k], sum_s[k]);

		// stage control
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		// stage data
		always_ff @(posedge clk) begin
			if (en) begin
				sum_s[k+1]   <= sum_s[k];
				rem_x_s[k+1] <= nx[RW:1];
				rem_y_s[k+1] <= ny[RW:1];
				quo_x_s[k+1] <= {quo_x_s[k][N-2:0], nx[0]};
				quo_y_s[k+1] <= {quo_y_s[k][N-2:0], ny[0]};
			end
		end
	end

	assign ctl_out = ctl_s[N];
	assign sum_out = sum_s[N];
	assign quo_x   = {{(RW-N){1'b0}}, quo_x_s[N]};
	assign quo_y   = {{(RW-N){1'b0}}, quo_y_s[N]};

endmodule

// ----- rtl/vnorm_sqrt.sv -----
// square root chain, one result digit per stage, three lanes: length, x, y
module vnorm_sqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  vnorm_pkg::ctl_t                 ctl_in,
	input  logic [vnorm_pkg::RemWidth-1:0]  rad_l,
	input  logic [vnorm_pkg::RemWidth-1:0]  rad_x,
	input  logic [vnorm_pkg::RemWidth-1:0]  rad_y,
	output vnorm_pkg::ctl_t                 ctl_out,
	output logic [vnorm_pkg::RemWidth-1:0]  root_l,
	output logic [vnorm_pkg::RemWidth-1:0]  root_x,
	output logic [vnorm_pkg::RemWidth-1:0]  root_y
);

	localparam int N  = vnorm_pkg::RootSteps;
	localparam int RW = vnorm_pkg::RemWidth;

	vnorm_pkg::ctl_t ctl_s [N+1];
	logic [RW-1:0]   rad_s [N+1][3];
	logic [RW-1:0]   res_s [N+1][3];

	assign ctl_s[0]    = ctl_in;
	assign rad_s[0][0] = rad_l;
	assign rad_s[0][1] = rad_x;
	assign rad_s[0][2] = rad_y;
	assign res_s[0][0] = '0;
	assign res_s[0][1] = '0;
	assign res_s[0][2] = '0;

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [RW-1:0] BitV = RW'(1) << (RW - 2 - 2 * k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		for (genvar j = 0; j < 3; j++) begin : g_lane
			logic [2*RW-1:0] nxt;
			assign nxt = vnorm_pkg::root_step(rad_s[k][j], res_s[k][j], BitV);

			always_ff @(posedge clk) begin
				if (en) begin
					res_s[k+1][j] <= nxt[2*RW-1:RW];
					rad_s[k+1][j] <= nxt[RW-1:0];
				end
			end
		end
	end

	assign ctl_out = ctl_s[N];
	assign root_l  = res_s[N][0];
	assign root_x  = res_s[N][1];
	assign root_y  = res_s[N][2];

endmodule
